// File: src/frc_pkg.sv
package frc_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int ADDR_W      = 7;
  localparam int SEQ_W       = 4;
  localparam int MASK_W      = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] REG_CHUNK_ID  = 2'd0;
  localparam logic [1:0] REG_CHUNK_LEN = 2'd1;
  localparam logic [1:0] REG_EXP_CRC   = 2'd2;
  localparam logic [1:0] REG_CRC_EN    = 2'd3;

  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } buf_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/frame_chunk_reassembler.sv
// frame_chunk_reassembler
// Command channel: an item (func, seq, chunk_tag, payload, payload_len) is
// taken at a clock edge with start high and busy low. busy stays high while
// the item is worked on. Each result appears on the result ports for one
// cycle with done high; the receiver cannot stall it, and the next item can
// be taken in the same cycle that done is shown.
// Work per item (clear and refused frame words go straight to the result):
//   frame word  stored: one buffer byte per cycle over the 8 byte lanes
//   check CRC   straight to the result when disabled, else one byte per
//               cycle through the byte-wide CRC step, fed by the buffer
//               read port (no bytes for an empty chunk)
//   read slot   eight byte reads through the registered read port
// Configuration goes through the APB port while the block is idle; the user
// must keep to this, as the block does not enforce it. pready is always high
// and reads return the stored register values. Reset sets chunk_id to 0xFF
// and clears the other registers, the received mask and all buffer valid
// bits, so the buffer reads as zeros; no clearing pass is needed.
module frame_chunk_reassembler #(
  parameter int MAX_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [3:0]  seq,
  input  logic [3:0]  chunk_tag,
  input  logic [63:0] payload,
  input  logic [3:0]  payload_len,
  output logic        done,
  output logic        accepted,
  output logic        complete,
  output logic [15:0] missing_mask,
  output logic        crc_ok,
  output logic [63:0] read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = frc_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_CRC,
    S_RD,
    S_FIN
  } state_t;

  state_t state;

  logic [7:0]  chunk_id;
  logic [7:0]  chunk_bytes;
  logic [15:0] expected_crc;
  logic        crc_check_enable;

  logic [15:0]   received_mask;
  frc_pkg::func_t func_q;
  logic          acc_q;
  logic [7:0]    cnt;
  logic          pend;
  logic [63:0]   pay_sh;
  logic [3:0]    wn;
  logic [AW-1:0] off;
  logic [15:0]   crc;
  logic [63:0]   rd_acc;

  frc_pkg::buf_req_t req;
  logic [7:0]        rbyte;

  logic        chunk_open;
  logic [4:0]  frame_count;
  logic [15:0] want;
  logic        frame_ok;
  logic [7:0]  rem;
  logic [3:0]  lim;
  logic [3:0]  plen_sat;
  logic        cfg_wr;
  logic [7:0]  len_sat;
  logic        issue;

  frc_buffer #(.MAX_BYTES(MAX_BYTES)) u_buf (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rbyte(rbyte)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign len_sat = (pwdata[7:0] > 8'(MAX_BYTES)) ? 8'(MAX_BYTES) : pwdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_id         <= 8'hFF;
      chunk_bytes      <= 8'h00;
      expected_crc     <= 16'h0000;
      crc_check_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        frc_pkg::REG_CHUNK_ID:  chunk_id         <= pwdata[7:0];
        frc_pkg::REG_CHUNK_LEN: chunk_bytes      <= len_sat;
        frc_pkg::REG_EXP_CRC:   expected_crc     <= pwdata[15:0];
        frc_pkg::REG_CRC_EN:    crc_check_enable <= pwdata[0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      frc_pkg::REG_CHUNK_ID:  prdata = {24'h0, chunk_id};
      frc_pkg::REG_CHUNK_LEN: prdata = {24'h0, chunk_bytes};
      frc_pkg::REG_EXP_CRC:   prdata = {16'h0, expected_crc};
      frc_pkg::REG_CRC_EN:    prdata = {31'h0, crc_check_enable};
      default:                prdata = 32'h0;
    endcase
  end

  // chunk status
  assign chunk_open  = !chunk_id[7] && (chunk_bytes != 8'h00);
  assign frame_count = 5'(({1'b0, chunk_bytes} + 9'd7) >> 3);

  always_comb begin
    for (int s = 0; s < frc_pkg::MASK_W; s++) begin
      want[s] = 5'(s) < frame_count;
    end
  end

  assign frame_ok = chunk_open && (chunk_tag == chunk_id[3:0])
                    && ({1'b0, seq} < frame_count);
  assign rem      = chunk_bytes - {1'b0, seq, 3'b000};
  assign lim      = (rem > 8'd8) ? 4'd8 : rem[3:0];
  assign plen_sat = (payload_len > 4'd8) ? 4'd8 : payload_len;

  // buffer requests
  assign issue = ((state == S_CRC) && (cnt < chunk_bytes))
              || ((state == S_RD) && (cnt < 8'd8));

  always_comb begin
    req.clr     = (state == S_IDLE) && start && (frc_pkg::func_t'(func) == frc_pkg::FUNC_CLEAR);
    req.wr_en   = (state == S_WR) && (cnt[3:0] < wn);
    req.wr_addr = off + AW'(cnt[2:0]);
    req.wr_data = pay_sh[63:56];
    req.rd_en   = issue;
    req.rd_addr = (state == S_CRC) ? cnt[AW-1:0] : off + AW'(cnt[2:0]);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      received_mask <= 16'h0000;
      done          <= 1'b0;
      cnt           <= 8'h00;
      pend          <= 1'b0;
      func_q        <= frc_pkg::FUNC_FRAME;
      acc_q         <= 1'b0;
      accepted      <= 1'b0;
      complete      <= 1'b0;
      missing_mask  <= 16'h0000;
      crc_ok        <= 1'b0;
      read_data     <= 64'h0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            func_q <= frc_pkg::func_t'(func);
            acc_q  <= 1'b0;
            cnt    <= 8'h00;
            pend   <= 1'b0;
            off    <= {seq, 3'b000};
            pay_sh <= payload;
            wn     <= (plen_sat < lim) ? plen_sat : lim;
            crc    <= frc_pkg::CRC_INIT;
            case (frc_pkg::func_t'(func))
              frc_pkg::FUNC_FRAME: begin
                if (frame_ok) begin
                  acc_q         <= 1'b1;
                  received_mask <= received_mask | (16'h0001 << seq);
                  state         <= S_WR;
                end else begin
                  state <= S_FIN;
                end
              end
              frc_pkg::FUNC_CLEAR: begin
                received_mask <= 16'h0000;
                state         <= S_FIN;
              end
              frc_pkg::FUNC_CHECK: state <= crc_check_enable ? S_CRC : S_FIN;
              default:             state <= S_RD;
            endcase
          end
        end
        S_WR: begin
          pay_sh <= {pay_sh[55:0], 8'h00};
          cnt    <= cnt + 8'd1;
          if (cnt[2:0] == 3'd7) begin
            state <= S_FIN;
          end
        end
        S_CRC, S_RD: begin
          if (pend) begin
            if (state == S_CRC) begin
              crc <= frc_pkg::crc_byte(crc, rbyte);
            end else begin
              rd_acc <= {rd_acc[55:0], rbyte};
            end
          end
          pend <= issue;
          if (issue) begin
            cnt <= cnt + 8'd1;
          end else if (!pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done         <= 1'b1;
          accepted     <= (func_q == frc_pkg::FUNC_FRAME) && acc_q;
          complete     <= chunk_open && ((received_mask & want) == want);
          missing_mask <= ~received_mask & want;
          crc_ok       <= (func_q == frc_pkg::FUNC_CHECK)
                          && (!crc_check_enable || (crc == expected_crc));
          read_data    <= (func_q == frc_pkg::FUNC_READ) ? rd_acc : 64'h0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");
  a_complete: assert property (@(posedge clk) disable iff (rst)
    (done && complete) |-> (missing_mask == 16'h0000))
    else $error("complete with frames missing");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("word taken without going busy");
`endif

endmodule

// File: src/frc_buffer.sv
module frc_buffer #(
  parameter int MAX_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  frc_pkg::buf_req_t req,
  output logic [7:0]       rbyte
);

  localparam int IW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [7:0]           mem [MAX_BYTES];
  logic [MAX_BYTES-1:0] vld;
  logic [7:0]           rdata;
  logic                 rbit;
  logic                 rd_in_range;

  assign rd_in_range = {1'b0, req.rd_addr} < (frc_pkg::ADDR_W+1)'(MAX_BYTES);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rbit <= 1'b0;
    end else begin
      if (req.clr) begin
        vld <= '0;
      end else if (req.wr_en) begin
        vld[req.wr_addr[IW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rbit <= rd_in_range && vld[req.rd_addr[IW-1:0]];
      end
    end
  end

  assign rbyte = rbit ? rdata : 8'h00;

endmodule

// File: verif/frame_chunk_reassembler_tb.sv
typedef struct packed {
  logic        accepted;
  logic        complete;
  logic [15:0] missing_mask;
  logic        crc_ok;
  logic [63:0] read_data;
} chunk_result_t;

class chunk_scoreboard;
  localparam int BUF_BYTES = 128;

  logic [7:0]    chunk_id;
  logic [7:0]    chunk_len;
  logic [15:0]   exp_crc;
  logic          crc_en;
  logic [7:0]    buffer [BUF_BYTES];
  logic [15:0]   rx_mask;
  chunk_result_t pending[$];
  int            errors;

  function new();
    chunk_id  = 8'hFF;
    chunk_len = 8'd0;
    exp_crc   = 16'h0000;
    crc_en    = 1'b0;
    rx_mask   = 16'h0000;
    errors    = 0;
    foreach (buffer[i]) buffer[i] = 8'h00;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      frc_pkg::REG_CHUNK_ID:  chunk_id = val[7:0];
      frc_pkg::REG_CHUNK_LEN: chunk_len = (val[7:0] > BUF_BYTES) ? 8'(BUF_BYTES) : val[7:0];
      frc_pkg::REG_EXP_CRC:   exp_crc = val[15:0];
      frc_pkg::REG_CRC_EN:    crc_en = val[0];
      default: ;
    endcase
  endfunction

  function bit chunk_open();
    return !chunk_id[7] && chunk_len != 8'd0;
  endfunction

  function int frame_total();
    return (int'(chunk_len) + frc_pkg::FRAME_BYTES - 1) / frc_pkg::FRAME_BYTES;
  endfunction

  function logic [15:0] chunk_crc();
    logic [15:0] c;
    c = frc_pkg::CRC_INIT;
    for (int i = 0; i < int'(chunk_len); i++) begin
      c = c ^ {buffer[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ frc_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function void note_word(frc_pkg::func_t f, logic [3:0] sq, logic [3:0] tag,
                          logic [63:0] pl, logic [3:0] plen);
    chunk_result_t r;
    int            fc;
    int            off;
    int            n;
    int            nbytes;
    logic [15:0]   want;
    r = '0;
    fc = frame_total();
    nbytes = (plen > frc_pkg::FRAME_BYTES) ? frc_pkg::FRAME_BYTES : int'(plen);
    case (f)
      frc_pkg::FUNC_FRAME: begin
        if (chunk_open() && tag == chunk_id[3:0] && int'(sq) < fc) begin
          off = int'(sq) * frc_pkg::FRAME_BYTES;
          n = int'(chunk_len) - off;
          if (n > frc_pkg::FRAME_BYTES) n = frc_pkg::FRAME_BYTES;
          for (int i = 0; i < n && i < nbytes; i++) begin
            if (off + i < BUF_BYTES) buffer[off + i] = pl[63 - 8 * i -: 8];
          end
          rx_mask[sq] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      frc_pkg::FUNC_CLEAR: begin
        rx_mask = 16'h0000;
        foreach (buffer[i]) buffer[i] = 8'h00;
      end
      frc_pkg::FUNC_CHECK: r.crc_ok = !crc_en || (chunk_crc() == exp_crc);
      default: begin
        for (int i = 0; i < frc_pkg::FRAME_BYTES; i++) begin
          off = int'(sq) * frc_pkg::FRAME_BYTES + i;
          r.read_data[63 - 8 * i -: 8] = (off < BUF_BYTES) ? buffer[off] : 8'h00;
        end
      end
    endcase
    want = (fc >= 16) ? 16'hFFFF : 16'((1 << fc) - 1);
    r.complete = chunk_open() && ((rx_mask & want) == want);
    r.missing_mask = ~rx_mask & want;
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_result(chunk_result_t got);
    chunk_result_t predicted;
    if (pending.size() == 0) begin
      report($sformatf("result word with nothing pending: %h", got));
      return;
    end
    predicted = pending.pop_front();
    if (got.accepted !== predicted.accepted)
      report($sformatf("accepted %b, want %b", got.accepted, predicted.accepted));
    if (got.complete !== predicted.complete)
      report($sformatf("complete %b, want %b", got.complete, predicted.complete));
    if (got.missing_mask !== predicted.missing_mask)
      report($sformatf("missing_mask %h, want %h", got.missing_mask, predicted.missing_mask));
    if (got.crc_ok !== predicted.crc_ok)
      report($sformatf("crc_ok %b, want %b", got.crc_ok, predicted.crc_ok));
    if (got.read_data !== predicted.read_data)
      report($sformatf("read_data %h, want %h", got.read_data, predicted.read_data));
  endtask
endclass

module frame_chunk_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = 2'd0;
  logic [3:0]  seq = 4'd0;
  logic [3:0]  chunk_tag = 4'd0;
  logic [63:0] payload = 64'd0;
  logic [3:0]  payload_len = 4'd0;
  logic        done;
  logic        accepted;
  logic        complete;
  logic [15:0] missing_mask;
  logic        crc_ok;
  logic [63:0] read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  chunk_scoreboard sb;
  int              sent;
  bit              no_gaps;

  frame_chunk_reassembler i_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result({accepted, complete, missing_mask, crc_ok, read_data});
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_word(input frc_pkg::func_t f, input logic [3:0] sq,
                           input logic [3:0] tag, input logic [63:0] pl,
                           input logic [3:0] plen);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    repeat ((gap == 0) ? 1 : gap) @(posedge clk);
    start       <= 1'b1;
    func        <= f;
    seq         <= sq;
    chunk_tag   <= tag;
    payload     <= pl;
    payload_len <= plen;
    do @(posedge clk); while (busy);
    sb.note_word(f, sq, tag, pl, plen);
    start <= 1'b0;
    sent++;
  endtask

  task automatic wait_results();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_chunk(input logic [7:0] id, input logic [7:0] len,
                           input logic [15:0] crc, input logic en);
    wait_idle();
    reg_write(frc_pkg::REG_CHUNK_ID, 32'(id));
    reg_write(frc_pkg::REG_CHUNK_LEN, 32'(len));
    reg_write(frc_pkg::REG_EXP_CRC, 32'(crc));
    reg_write(frc_pkg::REG_CRC_EN, 32'(en));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_noise();
    send_word(frc_pkg::func_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              ($urandom_range(0, 1) == 0) ? sb.chunk_id[3:0] : 4'($urandom_range(0, 15)),
              rand64(), 4'($urandom_range(0, 15)));
  endtask

  task automatic send_frame(input int s);
    logic [3:0] plen;
    plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    send_word(frc_pkg::FUNC_FRAME, 4'(s), sb.chunk_id[3:0], rand64(), plen);
  endtask

  task automatic random_phase();
    logic [7:0] id;
    logic [7:0] len;
    int         order [16];
    int         fc;
    int         j;
    int         tmp;
    case ($urandom_range(0, 9))
      0: id = 8'hFF;
      1: id = 8'h7F;
      2: id = 8'h00;
      default: id = 8'($urandom_range(0, 127));
    endcase
    case ($urandom_range(0, 11))
      0: len = 8'd0;
      1: len = 8'd128;
      2: len = 8'($urandom_range(129, 255));
      3: len = 8'(8 * $urandom_range(1, 4));
      4, 5: len = 8'($urandom_range(41, 127));
      default: len = 8'($urandom_range(1, 40));
    endcase
    set_chunk(id, len, 16'($urandom), 1'($urandom));
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) != 0)
      send_word(frc_pkg::FUNC_CLEAR, 4'd0, 4'd0, 64'd0, 4'd0);
    fc = sb.frame_total();
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = fc - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < fc; i++) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      if ($urandom_range(0, 15) == 0) wait_results();
      if ($urandom_range(0, 11) != 0) send_frame(order[i]);
    end
    if (fc > 0 && $urandom_range(0, 3) == 0) send_frame($urandom_range(0, fc - 1));
    send_word(frc_pkg::FUNC_CHECK, 4'($urandom_range(0, 15)), 4'd0, rand64(), 4'd0);
    send_word(frc_pkg::FUNC_READ, 4'($urandom_range(0, 15)), 4'd0, rand64(), 4'd0);
    if ($urandom_range(0, 1) == 0) begin
      wait_idle();
      reg_write(frc_pkg::REG_EXP_CRC, 32'(sb.chunk_crc()));
      reg_write(frc_pkg::REG_CRC_EN, 32'd1);
      send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // closed after reset: frame refused, check passes, buffer reads zero
    send_word(frc_pkg::FUNC_FRAME, 4'd0, 4'hF, '1, 4'd8);
    send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_READ, 4'd15, 4'd0, 64'd0, 4'd0);

    set_chunk(8'h05, 8'd20, 16'h1234, 1'b1);
    send_word(frc_pkg::FUNC_CLEAR, 4'd0, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_FRAME, 4'd2, 4'd5, '1, 4'd8);
    send_word(frc_pkg::FUNC_FRAME, 4'd0, 4'd5, 64'h0123_4567_89AB_CDEF, 4'd15);
    send_word(frc_pkg::FUNC_FRAME, 4'd1, 4'd5, rand64(), 4'd3);
    send_word(frc_pkg::FUNC_FRAME, 4'd1, 4'd6, rand64(), 4'd8);
    send_word(frc_pkg::FUNC_FRAME, 4'd3, 4'd5, rand64(), 4'd8);
    send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_READ, 4'd0, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_READ, 4'd1, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_READ, 4'd2, 4'd0, 64'd0, 4'd0);
    wait_idle();
    reg_write(frc_pkg::REG_EXP_CRC, 32'(sb.chunk_crc()));
    send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    // shorter chunk leaves a stale mask bit above the count
    wait_idle();
    reg_write(frc_pkg::REG_CHUNK_LEN, 32'd12);
    send_word(frc_pkg::FUNC_READ, 4'd1, 4'd0, 64'd0, 4'd0);

    // length saturates, full 16-frame mask
    set_chunk(8'h7F, 8'hFF, 16'hFFFF, 1'b1);
    send_word(frc_pkg::FUNC_CLEAR, 4'd0, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_FRAME, 4'd15, 4'hF, '1, 4'd8);
    send_word(frc_pkg::FUNC_READ, 4'd15, 4'd0, 64'd0, 4'd0);
    send_word(frc_pkg::FUNC_FRAME, 4'd15, 4'hF, 64'd0, 4'd8);
    send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    // empty chunk CRC
    wait_idle();
    reg_write(frc_pkg::REG_CHUNK_LEN, 32'd0);
    send_word(frc_pkg::FUNC_CHECK, 4'd0, 4'd0, 64'd0, 4'd0);
    set_chunk(8'hFF, 8'd128, 16'h0000, 1'b0);
    send_word(frc_pkg::FUNC_FRAME, 4'd0, 4'hF, rand64(), 4'd8);

    while (sent < 1775) random_phase();

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
src/frc_pkg.sv
src/frc_buffer.sv
src/frame_chunk_reassembler.sv
verif/frame_chunk_reassembler_tb.sv
